// ===== rtl/bsa_pkg.sv =====
package bsa_pkg;

    // Default build sizes.
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_SAMPLE_BITS = 8;

    // Fixed port field widths.
    localparam int SAMPLE_W = 8;
    localparam int COORD_W  = 10;
    localparam int SUM_W    = 12;
    localparam int DIM_W    = 11;

    // Reset value of both frame size registers.
    localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

    // Configuration register indexes.
    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    // Controls for the row store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ls_ctl;

    // Controls for the window and maximum tracker.
    typedef struct packed {
        logic shift;
        logic adv;
        logic s2_valid;
        logic s2_interior;
        logic s2_last;
    } t_trk_ctl;

endpackage

// ===== rtl/bsa_line_store.sv =====
module bsa_line_store #(
    parameter int  MAX_WIDTH = bsa_pkg::DEF_MAX_WIDTH,
    parameter int  SB        = bsa_pkg::DEF_SAMPLE_BITS,
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bsa_pkg::t_ls_ctl i_ctl,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [SB-1:0]    i_wr_sample,
    output logic [SB+1:0]    o_col_sum
);

    // Each entry holds {row before previous, previous row} for one column.
    logic [2*SB-1:0] r_mem [MAX_WIDTH];
    logic [2*SB-1:0] r_rdata;
    logic [2*SB-1:0] r_fwd_data;
    logic            r_fwd_hit;
    logic [2*SB-1:0] w_entry;
    logic [2*SB-1:0] w_wdata;

    // The registered read entry, or the one written in the same cycle as the read.
    assign w_entry = r_fwd_hit ? r_fwd_data : r_rdata;

    // The previous row moves up one slot and the new sample becomes the previous row.
    assign w_wdata = {w_entry[SB-1:0], i_wr_sample};

    // Three samples of one column.
    assign o_col_sum = (SB+2)'(w_entry[2*SB-1:SB]) + (SB+2)'(w_entry[SB-1:0])
                     + (SB+2)'(i_wr_sample);

    // Memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= w_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    // A read of the column being written in the same cycle takes the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_ctl.rd_en) begin
            r_fwd_hit <= i_ctl.wr_en && (i_rd_addr == i_wr_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_fwd_data <= w_wdata;
        end
    end

endmodule

// ===== rtl/bsa_track.sv =====
module bsa_track #(
    parameter int  MAX_WIDTH  = bsa_pkg::DEF_MAX_WIDTH,
    parameter int  MAX_HEIGHT = bsa_pkg::DEF_MAX_HEIGHT,
    parameter int  SB         = bsa_pkg::DEF_SAMPLE_BITS,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int RW         = $clog2(MAX_HEIGHT)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bsa_pkg::t_trk_ctl            i_ctl,
    input  logic [SB+1:0]                i_col_sum,
    input  logic [CW-1:0]                i_x,
    input  logic [RW-1:0]                i_y,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [bsa_pkg::COORD_W-1:0]  o_best_x,
    output logic [bsa_pkg::COORD_W-1:0]  o_best_y,
    output logic [bsa_pkg::SUM_W-1:0]    o_best_sum
);
    import bsa_pkg::*;

    localparam int SW = SB + 4;

    logic [SB+1:0] r_wc0, r_wc1, r_wc2;
    logic [SW-1:0] w_sum;
    logic [SW-1:0] r_max_sum, n_max_sum;
    logic [CW-1:0] r_max_x, n_max_x;
    logic [RW-1:0] r_max_y, n_max_y;
    logic          r_out_valid;
    logic [CW-1:0] r_out_x;
    logic [RW-1:0] r_out_y;
    logic [SW-1:0] r_out_sum;
    logic          w_take;
    logic          w_better;
    logic          w_emit;

    // Three most recent column sums form the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc0 <= '0;
            r_wc1 <= '0;
            r_wc2 <= '0;
        end else if (i_ctl.shift) begin
            r_wc0 <= r_wc1;
            r_wc1 <= r_wc2;
            r_wc2 <= i_col_sum;
        end
    end

    assign w_sum = SW'(r_wc0) + SW'(r_wc1) + SW'(r_wc2);

    // Strict greater-than keeps the first maximum in raster order.
    assign w_take   = i_ctl.adv && i_ctl.s2_valid;
    assign w_better = w_take && i_ctl.s2_interior && (w_sum > r_max_sum);
    assign w_emit   = w_take && i_ctl.s2_last;

    always_comb begin
        n_max_sum = r_max_sum;
        n_max_x   = r_max_x;
        n_max_y   = r_max_y;
        if (w_better) begin
            n_max_sum = w_sum;
            n_max_x   = i_x - CW'(1);
            n_max_y   = i_y - RW'(1);
        end
    end

    // Running best and result valid; a frame end hands the best over and clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sum   <= '0;
            r_max_x     <= '0;
            r_max_y     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_max_sum   <= '0;
            r_max_x     <= '0;
            r_max_y     <= '0;
            r_out_valid <= 1'b1;
        end else begin
            r_max_sum <= n_max_sum;
            r_max_x   <= n_max_x;
            r_max_y   <= n_max_y;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_x   <= n_max_x;
            r_out_y   <= n_max_y;
            r_out_sum <= n_max_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_best_x    = COORD_W'(r_out_x);
    assign o_best_y    = COORD_W'(r_out_y);
    assign o_best_sum  = SUM_W'(r_out_sum);

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_out_valid && (r_max_sum == '0))
        else $error("frame end did not load the result and clear the best sum");

    a_best_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_emit |=> r_max_sum >= $past(r_max_sum))
        else $error("best sum dropped within a frame");

endmodule

// ===== rtl/box3x3_sum_argmax.sv =====
// Streaming 3x3 box-sum search. Samples of a frame arrive in raster order, one transfer
// each, and the block may take one sample every clock. The frame size comes from the
// frame_width and frame_height registers (0 acts as 1, values above MAX_WIDTH or
// MAX_HEIGHT act as the maximum); write them only between frames. For every position
// not on the frame border the 3x3 window sum is formed, and the largest sum with its
// center column and row is kept; ties keep the earlier window. The result of a frame
// is registered as its last sample leaves the s2 stage, and the tracker clears. Frames
// narrower or shorter than 3 report (0,0) with sum 0. The two previous rows sit in one
// MAX_WIDTH-deep memory that is read when a sample is accepted and written back when
// that sample leaves the s1 stage, so one sample per cycle holds for any frame width. The
// input stalls only while a frame result has not been taken and the next frame's last
// sample has reached the final stage.
module box3x3_sum_argmax #(
    parameter int MAX_WIDTH   = bsa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = bsa_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = bsa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  bsa_pkg::t_cfg_index          i_cfg_index,
    input  logic [bsa_pkg::DIM_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bsa_pkg::SAMPLE_W-1:0] i_sample,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bsa_pkg::COORD_W-1:0]  o_best_x,
    output logic [bsa_pkg::COORD_W-1:0]  o_best_y,
    output logic [bsa_pkg::SUM_W-1:0]    o_best_sum
);
    import bsa_pkg::*;

    localparam int SB  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CXW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int CYW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;

    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [CW:0]      w_col_inc;
    logic [RW:0]      w_row_inc;
    logic             w_row_end;
    logic             w_last_row;
    logic             w_interior;
    logic             w_freeze;
    logic             w_adv;
    logic             w_accept;

    logic             r_s1_valid;
    logic [SB-1:0]    r_s1_sample;
    logic [CW-1:0]    r_s1_x;
    logic [RW-1:0]    r_s1_y;
    logic             r_s1_interior;
    logic             r_s1_last;
    logic             r_s2_valid;
    logic [CW-1:0]    r_s2_x;
    logic [RW-1:0]    r_s2_y;
    logic             r_s2_interior;
    logic             r_s2_last;

    logic [SB+1:0]    w_col_sum;
    t_ls_ctl          w_ls_ctl;
    t_trk_ctl         w_trk_ctl;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_RESET;
            r_frame_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline holds only when a frame result cannot leave.
    assign w_freeze   = r_s2_valid && r_s2_last && o_out_valid && i_out_stall;
    assign w_adv      = !w_freeze;
    assign w_accept   = i_in_valid && w_adv;
    assign o_in_stall = w_freeze;

    // Row and frame ends against the clamped frame size.
    assign w_col_inc  = (CW+1)'(r_col) + (CW+1)'(1);
    assign w_row_inc  = (RW+1)'(r_row) + (RW+1)'(1);
    assign w_row_end  = (r_frame_width == '0) || (CXW'(w_col_inc) >= CXW'(r_frame_width))
                     || (r_col == CW'(MAX_WIDTH - 1));
    assign w_last_row = (r_frame_height == '0) || (CYW'(w_row_inc) >= CYW'(r_frame_height))
                     || (r_row == RW'(MAX_HEIGHT - 1));
    assign w_interior = (r_col >= CW'(2)) && (r_row >= RW'(2));

    always_comb begin
        n_col = w_col_inc[CW-1:0];
        n_row = r_row;
        if (w_row_end) begin
            n_col = '0;
            n_row = w_last_row ? '0 : w_row_inc[RW-1:0];
        end
    end

    // Raster position and stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_accept) begin
                r_s1_sample   <= i_sample[SB-1:0];
                r_s1_x        <= r_col;
                r_s1_y        <= r_row;
                r_s1_interior <= w_interior;
                r_s1_last     <= w_row_end && w_last_row;
            end
            r_s2_x        <= r_s1_x;
            r_s2_y        <= r_s1_y;
            r_s2_interior <= r_s1_interior;
            r_s2_last     <= r_s1_last;
        end
    end

    // Row store: read on accept, written back by the same sample when it leaves the s1 stage.
    assign w_ls_ctl.rd_en = w_accept;
    assign w_ls_ctl.wr_en = r_s1_valid && w_adv;

    bsa_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .SB        (SB)
    ) u_line_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ls_ctl),
        .i_rd_addr   (r_col),
        .i_wr_addr   (r_s1_x),
        .i_wr_sample (r_s1_sample),
        .o_col_sum   (w_col_sum)
    );

    // Window sum, best tracking and result register.
    assign w_trk_ctl.shift       = r_s1_valid && w_adv;
    assign w_trk_ctl.adv         = w_adv;
    assign w_trk_ctl.s2_valid    = r_s2_valid;
    assign w_trk_ctl.s2_interior = r_s2_interior;
    assign w_trk_ctl.s2_last     = r_s2_last;

    bsa_track #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SB         (SB)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_trk_ctl),
        .i_col_sum   (w_col_sum),
        .i_x         (r_s2_x),
        .i_y         (r_s2_y),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_best_x    (o_best_x),
        .o_best_y    (o_best_y),
        .o_best_sum  (o_best_sum)
    );

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_freeze |=> r_s2_valid && r_s2_last)
        else $error("frame end left the last stage while its result was blocked");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_row_end |=> r_col == '0)
        else $error("column counter did not wrap at row end");

endmodule
